// File: rtl/mi4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mi4_pkg;

  localparam int ENTRIES   = 16;
  localparam int CNT_W     = 4;
  localparam int PC_W      = 5;
  localparam int MINOR_W   = 65;   // exact 2x2 minor
  localparam int COF_W     = 96;   // exact 3x3 cofactor
  localparam int ACC_W     = 136;  // accumulators for cofactor and determinant
  localparam int DET_MAG_W = 130;  // |det| < 2^129
  localparam int PROD_W    = 66;
  localparam int OPND_W    = 33;
  localparam int Q_W       = 33;   // quotient bits kept; top bit flags overflow

  localparam logic [PC_W-1:0]  PC_COF     = 5'd1;
  localparam logic [PC_W-1:0]  PC_DET     = 5'd13;
  localparam logic [PC_W-1:0]  PC_DIVLD   = 5'd16;
  localparam logic [PC_W-1:0]  PC_LAST    = 5'd18;
  localparam logic [CNT_W-1:0] ENTRY_LAST = 4'd15;
  localparam logic [CNT_W-1:0] LIMB_LAST  = 4'd3;

  typedef enum logic [2:0] {OP_WAIT, OP_MAC, OP_DIVLD, OP_DIV, OP_EMIT} op_t;
  typedef enum logic [2:0] {B_MAT, B_MLO, B_MHI, B_C0, B_C1, B_C2} bsrc_t;
  typedef enum logic [1:0] {DST_MLOAD, DST_MSUB, DST_ACC, DST_DET} dst_t;

  typedef struct packed {
    op_t             op;
    logic [1:0]      a_row;
    logic [1:0]      a_col;
    logic [1:0]      b_row;
    logic [1:0]      b_col;
    bsrc_t           b_src;
    dst_t            dst;
    logic            sub;
    logic            clr;
    logic            store;
    logic [1:0]      sh;
    logic            jmp;
    logic [PC_W-1:0] target;
    logic [CNT_W-1:0] lim;
  } uword_t;

  typedef struct packed {
    uword_t           uw;
    logic [1:0]       ph;
    logic [CNT_W-1:0] cnt;
    logic             load_we;
    logic [CNT_W-1:0] load_addr;
  } ctrl_t;

  // index of the n-th row/column of a 3x3 minor that skips x
  function automatic logic [1:0] skip_idx(logic [1:0] n, logic [1:0] x);
    return (n < x) ? n : n + 2'd1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mi4_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mi4_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

`default_nettype wire

// File: rtl/mi4_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mi4_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] inverse_value;
  logic [3:0]         element_index;
  logic               singular;
  logic               clamped;
  logic               last_entry;

  modport source (output valid, output inverse_value, output element_index,
                  output singular, output clamped, output last_entry, input ready);
  modport sink (input valid, input inverse_value, input element_index,
                input singular, input clamped, input last_entry, output ready);
endinterface

`default_nettype wire

// File: rtl/mi4_div.sv
`timescale 1ns / 1ps
`default_nettype none

module mi4_div #(
  parameter int NUM_W = 128,
  parameter int DEN_W = 130
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [NUM_W-1:0]         num,
  input  logic [DEN_W-1:0]         den,
  input  logic                     neg,
  output logic                     done,
  output logic [mi4_pkg::Q_W-1:0]  quot,
  output logic                     quot_neg
);
  import mi4_pkg::*;

  localparam int SH_W   = DEN_W + Q_W - 1;
  localparam int RW     = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int STEP_W = $clog2(Q_W);

  logic [RW-1:0]     rem;
  logic [RW-1:0]     dsh;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(Q_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= RW'(num);
      dsh      <= RW'(den) << (Q_W - 1);
      quot     <= '0;
      quot_neg <= neg;
    end else if (busy) begin
      if (ge) rem <= rem - dsh;
      quot <= {quot[Q_W-2:0], ge};
      dsh  <= dsh >> 1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mi4_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mi4_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  mi4_pkg::ctrl_t      ctrl,
  input  logic signed [31:0]  element_value,
  output logic                div_done,
  output logic signed [31:0]  inverse_value,
  output logic                singular,
  output logic                clamped
);
  import mi4_pkg::*;

  localparam int NUM_W = COF_W + 2 * FRAC_BITS;

  logic [31:0]                mat [ENTRIES];
  logic [COF_W-1:0]           adj [ENTRIES];
  logic signed [31:0]         mat_a;
  logic signed [31:0]         mat_b;
  logic [COF_W-1:0]           adj_rd;
  logic [CNT_W-1:0]           addr_a;
  logic [CNT_W-1:0]           addr_b;
  logic [CNT_W-1:0]           adj_raddr;
  logic [1:0]                 ci;
  logic [1:0]                 cj;
  logic signed [OPND_W-1:0]   op_a;
  logic signed [OPND_W-1:0]   op_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [ACC_W-1:0]    addend;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_next;
  logic signed [ACC_W-1:0]    det;
  logic signed [MINOR_W-1:0]  minor;
  logic                       sub_eff;
  logic                       mul_en;
  logic                       acc_en;
  logic                       div_start;
  logic [COF_W-1:0]           adj_mag;
  logic [ACC_W-1:0]           det_abs;
  logic [NUM_W-1:0]           num;
  logic [Q_W-1:0]             quot;
  logic                       quot_neg;
  logic                       det_zero;
  logic                       big;

  assign ci = ctrl.cnt[1:0];
  assign cj = ctrl.cnt[3:2];

  always_comb begin
    addr_b = {skip_idx(ctrl.uw.b_row, ci), skip_idx(ctrl.uw.b_col, cj)};
    if (ctrl.uw.dst == DST_DET) begin
      addr_a = {2'b00, ctrl.cnt[1:0]};
    end else begin
      addr_a = {skip_idx(ctrl.uw.a_row, ci), skip_idx(ctrl.uw.a_col, cj)};
    end
    if (ctrl.uw.op == OP_DIVLD) begin
      adj_raddr = ctrl.cnt;
    end else begin
      adj_raddr = {ctrl.cnt[1:0], 2'b00};  // cofactor (0,k)
    end
  end

  assign mul_en    = (ctrl.uw.op == OP_MAC) && (ctrl.ph == 2'd1);
  assign acc_en    = (ctrl.uw.op == OP_MAC) && (ctrl.ph == 2'd2);
  assign div_start = (ctrl.uw.op == OP_DIVLD) && (ctrl.ph == 2'd1);

  always_ff @(posedge clk) begin
    if (ctrl.load_we) mat[ctrl.load_addr] <= element_value;
    mat_a <= mat[addr_a];
    mat_b <= mat[addr_b];
  end

  always_ff @(posedge clk) begin
    if (acc_en && ctrl.uw.store) adj[ctrl.cnt] <= acc_next[COF_W-1:0];
    adj_rd <= adj[adj_raddr];
  end

  always_comb begin
    op_a = {mat_a[31], mat_a};
    case (ctrl.uw.b_src)
      B_MAT:   op_b = {mat_b[31], mat_b};
      B_MLO:   op_b = {1'b0, minor[31:0]};
      B_MHI:   op_b = minor[64:32];
      B_C0:    op_b = {1'b0, adj_rd[31:0]};
      B_C1:    op_b = {1'b0, adj_rd[63:32]};
      B_C2:    op_b = {adj_rd[95], adj_rd[95:64]};
      default: op_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= op_a * op_b;
  end

  // cofactor sign (-1)^(i+j) folds into the add/subtract choice
  always_comb begin
    prod_ext = ACC_W'(prod);
    case (ctrl.uw.sh)
      2'd0:    shifted = prod_ext;
      2'd1:    shifted = prod_ext <<< 32;
      default: shifted = prod_ext <<< 64;
    endcase
    sub_eff  = ctrl.uw.sub ^ ((ctrl.uw.dst == DST_ACC) && (ci[0] ^ cj[0]));
    addend   = sub_eff ? -shifted : shifted;
    acc_next = ctrl.uw.clr ? addend : acc + addend;
  end

  always_ff @(posedge clk) begin
    if (acc_en) begin
      case (ctrl.uw.dst)
        DST_MLOAD: minor <= prod[MINOR_W-1:0];
        DST_MSUB:  minor <= minor - prod[MINOR_W-1:0];
        DST_ACC:   acc   <= acc_next;
        default:   det   <= det + addend;
      endcase
    end
    if (ctrl.uw.op == OP_WAIT) det <= '0;
  end

  always_comb begin
    adj_mag = adj_rd[COF_W-1] ? (~adj_rd + 1'b1) : adj_rd;
    det_abs = det[ACC_W-1] ? ACC_W'(-det) : ACC_W'(det);
    num     = {adj_mag, {(2 * FRAC_BITS){1'b0}}};
  end

  mi4_div #(
    .NUM_W (NUM_W),
    .DEN_W (DET_MAG_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (num),
    .den      (det_abs[DET_MAG_W-1:0]),
    .neg      (adj_rd[COF_W-1] ^ det[ACC_W-1]),
    .done     (div_done),
    .quot     (quot),
    .quot_neg (quot_neg)
  );

  always_comb begin
    det_zero = (det == '0);
    big      = quot[Q_W-1];
    singular = det_zero;
    if (det_zero) begin
      clamped       = 1'b0;
      inverse_value = '0;
    end else begin
      if (quot_neg) begin
        clamped = big || (quot[31] && (quot[30:0] != '0));
      end else begin
        clamped = big || quot[31];
      end
      if (clamped) begin
        inverse_value = quot_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        inverse_value = quot_neg ? -signed'(quot[31:0]) : signed'(quot[31:0]);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mi4_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module mi4_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_fire,
  input  logic            div_done,
  output logic            in_ready,
  output logic            out_valid,
  output mi4_pkg::ctrl_t  ctrl
);
  import mi4_pkg::*;

  logic [PC_W-1:0]  pc;
  logic [PC_W-1:0]  pc_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [1:0]       ph;
  logic [1:0]       ph_next;
  logic [CNT_W-1:0] load_count;
  logic             step_done;
  uword_t           uw;

  function automatic uword_t mac(logic [1:0] ar, logic [1:0] ac, bsrc_t bs,
                                 logic [1:0] br, logic [1:0] bc, dst_t d,
                                 logic sb, logic cl, logic [1:0] s);
    uword_t w;
    w       = '0;
    w.op    = OP_MAC;
    w.a_row = ar;
    w.a_col = ac;
    w.b_src = bs;
    w.b_row = br;
    w.b_col = bc;
    w.dst   = d;
    w.sub   = sb;
    w.clr   = cl;
    w.sh    = s;
    return w;
  endfunction

  // microprogram: 3x3 cofactor by minors, determinant by row 0, then divide/emit
  always_comb begin
    uw = '0;
    case (pc)
      5'd0:  uw.op = OP_WAIT;
      5'd1:  uw = mac(2'd1, 2'd1, B_MAT, 2'd2, 2'd2, DST_MLOAD, 1'b0, 1'b0, 2'd0);
      5'd2:  uw = mac(2'd1, 2'd2, B_MAT, 2'd2, 2'd1, DST_MSUB,  1'b0, 1'b0, 2'd0);
      5'd3:  uw = mac(2'd0, 2'd0, B_MLO, 2'd0, 2'd0, DST_ACC,   1'b0, 1'b1, 2'd0);
      5'd4:  uw = mac(2'd0, 2'd0, B_MHI, 2'd0, 2'd0, DST_ACC,   1'b0, 1'b0, 2'd1);
      5'd5:  uw = mac(2'd1, 2'd0, B_MAT, 2'd2, 2'd2, DST_MLOAD, 1'b0, 1'b0, 2'd0);
      5'd6:  uw = mac(2'd1, 2'd2, B_MAT, 2'd2, 2'd0, DST_MSUB,  1'b0, 1'b0, 2'd0);
      5'd7:  uw = mac(2'd0, 2'd1, B_MLO, 2'd0, 2'd0, DST_ACC,   1'b1, 1'b0, 2'd0);
      5'd8:  uw = mac(2'd0, 2'd1, B_MHI, 2'd0, 2'd0, DST_ACC,   1'b1, 1'b0, 2'd1);
      5'd9:  uw = mac(2'd1, 2'd0, B_MAT, 2'd2, 2'd1, DST_MLOAD, 1'b0, 1'b0, 2'd0);
      5'd10: uw = mac(2'd1, 2'd1, B_MAT, 2'd2, 2'd0, DST_MSUB,  1'b0, 1'b0, 2'd0);
      5'd11: uw = mac(2'd0, 2'd2, B_MLO, 2'd0, 2'd0, DST_ACC,   1'b0, 1'b0, 2'd0);
      5'd12: begin
        uw        = mac(2'd0, 2'd2, B_MHI, 2'd0, 2'd0, DST_ACC, 1'b0, 1'b0, 2'd1);
        uw.store  = 1'b1;
        uw.jmp    = 1'b1;
        uw.target = PC_COF;
        uw.lim    = ENTRY_LAST;
      end
      5'd13: uw = mac(2'd0, 2'd0, B_C0, 2'd0, 2'd0, DST_DET, 1'b0, 1'b0, 2'd0);
      5'd14: uw = mac(2'd0, 2'd0, B_C1, 2'd0, 2'd0, DST_DET, 1'b0, 1'b0, 2'd1);
      5'd15: begin
        uw        = mac(2'd0, 2'd0, B_C2, 2'd0, 2'd0, DST_DET, 1'b0, 1'b0, 2'd2);
        uw.jmp    = 1'b1;
        uw.target = PC_DET;
        uw.lim    = LIMB_LAST;
      end
      5'd16: uw.op = OP_DIVLD;
      5'd17: uw.op = OP_DIV;
      5'd18: begin
        uw.op     = OP_EMIT;
        uw.jmp    = 1'b1;
        uw.target = PC_DIVLD;
        uw.lim    = ENTRY_LAST;
      end
      default: uw.op = OP_WAIT;
    endcase
  end

  always_comb begin
    case (uw.op)
      OP_WAIT:  step_done = in_fire && (load_count == ENTRY_LAST);
      OP_MAC:   step_done = (ph == 2'd2);
      OP_DIVLD: step_done = (ph == 2'd1);
      OP_DIV:   step_done = div_done;
      OP_EMIT:  step_done = out_fire;
      default:  step_done = 1'b0;
    endcase
  end

  always_comb begin
    pc_next  = pc;
    cnt_next = cnt;
    ph_next  = ph;
    if (step_done) begin
      ph_next = '0;
      if (uw.jmp && (cnt != uw.lim)) begin
        pc_next  = uw.target;
        cnt_next = cnt + 1'b1;
      end else begin
        if (uw.jmp) cnt_next = '0;
        pc_next = (pc == PC_LAST) ? '0 : pc + 1'b1;
      end
    end else if ((uw.op == OP_MAC) || (uw.op == OP_DIVLD)) begin
      ph_next = ph + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= '0;
      cnt        <= '0;
      ph         <= '0;
      load_count <= '0;
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
      ph  <= ph_next;
      if (in_fire) load_count <= load_count + 1'b1;
    end
  end

  assign in_ready  = (uw.op == OP_WAIT);
  assign out_valid = (uw.op == OP_EMIT);

  always_comb begin
    ctrl           = '0;
    ctrl.uw        = uw;
    ctrl.ph        = ph;
    ctrl.cnt       = cnt;
    ctrl.load_we   = in_fire;
    ctrl.load_addr = load_count;
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc <= PC_LAST)
    else $error("sequencer ran past the last step");

  a_phase_idle: assert property (@(posedge clk) disable iff (rst)
    (uw.op != OP_MAC && uw.op != OP_DIVLD) |-> ph == 2'd0)
    else $error("phase counter moved outside a multi-cycle step");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && load_count == ENTRY_LAST) |=> (pc == PC_COF && cnt == '0))
    else $error("sixteenth entry did not start the cofactor loop");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_fire && cnt == ENTRY_LAST) |=> (pc == '0 && load_count == '0))
    else $error("last result did not return to loading");

endmodule

`default_nettype wire

// File: rtl/matrix4_cofactor_inverse.sv
// Operation: 16 input transactions load the matrix, then the cofactors and determinant
// are formed in 204 multiply steps on one 33x33 multiplier, then each result takes an
// operand load, a pass of the 33-step bit-serial divider and an output handshake.
// One matrix is processed at a time; inputs are held off while results drain.
// Reset (rst, synchronous, active high) returns the sequencer to loading with a zero count.
`timescale 1ns / 1ps
`default_nettype none

module matrix4_cofactor_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  mi4_in_if.sink    elem_in,
  mi4_out_if.source inv_out
);
  import mi4_pkg::*;

  ctrl_t ctrl;
  logic  in_fire;
  logic  out_fire;
  logic  in_ready;
  logic  out_valid;
  logic  div_done;

  assign in_fire  = elem_in.valid && in_ready;
  assign out_fire = out_valid && inv_out.ready;

  mi4_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .div_done  (div_done),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  mi4_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .element_value (elem_in.element_value),
    .div_done      (div_done),
    .inverse_value (inv_out.inverse_value),
    .singular      (inv_out.singular),
    .clamped       (inv_out.clamped)
  );

  assign elem_in.ready         = in_ready;
  assign inv_out.valid         = out_valid;
  assign inv_out.element_index = ctrl.cnt;
  assign inv_out.last_entry    = (ctrl.cnt == ENTRY_LAST);

endmodule

`default_nettype wire
